// File: hdl/bicycle_model_dead_reckoning_unit_defines.svh
// assertion helpers used by the top-level rtl file
`ifndef BICYCLE_MODEL_DEAD_RECKONING_UNIT_DEFINES_SVH
`define BICYCLE_MODEL_DEAD_RECKONING_UNIT_DEFINES_SVH

// property that must hold at every edge outside reset
`define BMDR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define BMDR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/bmdr_pkg.sv
package bmdr_pkg;

  localparam logic signed [35:0] CordicX0 = 36'sd652032874;
  localparam logic [29:0] BinPerRad = 30'd683565276;
  localparam logic signed [63:0] TanMax = 64'sd2147483647;

  localparam logic CfgInvWheelbase = 1'b0;
  localparam logic CfgSteerToWheel = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ANGLE, ST_CORD1, ST_DIV, ST_YAW1, ST_YAW2, ST_CORD2,
    ST_POS1, ST_POS2, ST_CORD3, ST_OUT
  } state_e;

  // what one cordic stage passes to the next
  typedef struct packed {
    logic signed [35:0] x;
    logic signed [35:0] y;
    logic signed [33:0] z;
    logic               flip;
  } cordic_vec_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
      5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
      5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
      5'd6: r = 32'd10679838;   5'd7: r = 32'd5340245;
      5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
      5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;     5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;       5'd21: r = 32'd326;
      5'd22: r = 32'd163;       5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] q15(input logic signed [35:0] v);
    logic signed [36:0] r;
    logic [15:0] o;
    r = (37'(v) + 37'sd16384) >>> 15;
    if (r > 37'sd32767) o = 16'h7fff;
    else if (r < -37'sd32768) o = 16'h8000;
    else o = r[15:0];
    return o;
  endfunction

endpackage

// File: hdl/bmdr_if.sv
interface bmdr_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] speed;
  logic signed [15:0] steer_pos;
  logic [19:0]        time_step;
  modport source (output valid, speed, steer_pos, time_step, input ready);
  modport sink (input valid, speed, steer_pos, time_step, output ready);
endinterface

interface bmdr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [31:0]        heading;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;
  modport source (output valid, pos_x, pos_y, heading, quat_z, quat_w, input ready);
  modport sink (input valid, pos_x, pos_y, heading, quat_z, quat_w, output ready);
endinterface

// File: hdl/bicycle_model_dead_reckoning_unit.sv
// bicycle-model dead reckoning
// in_bus carries one vehicle sample per beat (speed, steer_pos, time_step);
// out_bus returns exactly one pose beat per sample (pos_x, pos_y, heading,
// quat_z, quat_w). cfg_we_i/cfg_idx_i/cfg_wdata_i write inv_wheelbase (0)
// and steer_to_wheel (1); other indexes are dropped.
// one sample at a time: in_bus.ready is high only while no sample is held.
// the pose beat is offered after three passes down the cordic cell row
// (tangent, position heading, quaternion) plus a bit-serial tangent divide.
// the result waits in the output register while out_bus.ready is low; the
// next sample is taken once the result beat leaves.
// reset clears yaw and position to zero and restores the register defaults.
`include "bicycle_model_dead_reckoning_unit_defines.svh"

module bicycle_model_dead_reckoning_unit #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  bmdr_in_if.sink     in_bus,
  bmdr_out_if.source  out_bus
);
  bmdr_pkg::state_e st_q, st_d;
  logic [15:0] inv_wb_q, s2w_q;
  logic [31:0] yaw_q, x_q, y_q;
  logic signed [15:0] v_q;
  logic signed [32:0] m_q;
  logic [19:0] dt_q;
  logic [31:0] ang_q;
  logic signed [63:0] t_q, amp_q, h_q, tmp_q, dx_q, dy_q;
  logic signed [15:0] qz_q, qw_q;
  logic cstart, cstart_q, cdone, dstart, ddone;
  logic signed [35:0] ccos, csin;
  logic signed [63:0] dquot;
  logic out_vld_q;
  logic signed [63:0] pxs, pys;

  // config index 1 bit wide; wider writes not addressable here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_wb_q <= 16'd24545;
      s2w_q    <= 16'd15735;
    end else if (cfg_we_i) begin
      if (cfg_idx_i[0] == bmdr_pkg::CfgInvWheelbase) inv_wb_q <= cfg_wdata_i;
      else s2w_q <= cfg_wdata_i;
    end
  end

  // the row start is registered so that it meets the newly loaded angle register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cstart_q <= 1'b0;
    end else begin
      cstart_q <= cstart;
    end
  end

  bmdr_cordic_chain #(.CordicSteps(CORDIC_STEPS)) u_chain (
    .clk_i, .rst_ni, .start_i(cstart_q), .ang_i(ang_q),
    .done_o(cdone), .cos_o(ccos), .sin_o(csin)
  );

  bmdr_divider u_div (
    .clk_i, .rst_ni, .start_i(dstart), .num_i(csin), .den_i(ccos),
    .done_o(ddone), .quot_o(dquot)
  );

  assign in_bus.ready = (st_q == bmdr_pkg::ST_IDLE);

  always_comb begin
    st_d = st_q;
    cstart = 1'b0;
    dstart = 1'b0;
    unique case (st_q)
      bmdr_pkg::ST_IDLE:  if (in_bus.valid) st_d = bmdr_pkg::ST_ANGLE;
      bmdr_pkg::ST_ANGLE: begin cstart = 1'b1; st_d = bmdr_pkg::ST_CORD1; end
      bmdr_pkg::ST_CORD1: if (cdone) begin dstart = 1'b1; st_d = bmdr_pkg::ST_DIV; end
      bmdr_pkg::ST_DIV:   if (ddone) st_d = bmdr_pkg::ST_YAW1;
      bmdr_pkg::ST_YAW1:  st_d = bmdr_pkg::ST_YAW2;
      bmdr_pkg::ST_YAW2:  begin cstart = 1'b1; st_d = bmdr_pkg::ST_CORD2; end
      bmdr_pkg::ST_CORD2: if (cdone) st_d = bmdr_pkg::ST_POS1;
      bmdr_pkg::ST_POS1:  begin cstart = 1'b1; st_d = bmdr_pkg::ST_POS2; end
      bmdr_pkg::ST_POS2:  st_d = bmdr_pkg::ST_CORD3;
      bmdr_pkg::ST_CORD3: if (cdone) st_d = bmdr_pkg::ST_OUT;
      bmdr_pkg::ST_OUT:   if (out_bus.ready) st_d = bmdr_pkg::ST_IDLE;
      default:            st_d = bmdr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= bmdr_pkg::ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_comb begin
    pxs = 64'($signed(x_q)) + (dx_q >>> 32);
    pys = 64'($signed(y_q)) + (dy_q >>> 32);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yaw_q <= '0;
      x_q   <= '0;
      y_q   <= '0;
    end else begin
      if (st_q == bmdr_pkg::ST_YAW2) yaw_q <= yaw_q + tmp_q[63:32];
      if (st_q == bmdr_pkg::ST_POS2) begin
        x_q <= (pxs > 64'sd2147483647) ? 32'h7fffffff :
               (pxs < -64'sd2147483648) ? 32'h80000000 : pxs[31:0];
        y_q <= (pys > 64'sd2147483647) ? 32'h7fffffff :
               (pys < -64'sd2147483648) ? 32'h80000000 : pys[31:0];
      end
    end
  end

  // datapath: products registered per state; amp*t is split over ST_DIV and ST_YAW1
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      bmdr_pkg::ST_IDLE: begin
        v_q  <= in_bus.speed;
        m_q  <= 33'(in_bus.steer_pos * $signed({1'b0, s2w_q}));
        dt_q <= in_bus.time_step;
        h_q  <= 64'(in_bus.speed * $signed({1'b0, in_bus.time_step}));
      end
      bmdr_pkg::ST_ANGLE: begin
        ang_q <= 32'((64'(m_q) * $signed({1'b0, bmdr_pkg::BinPerRad})
                 + 64'sd536870912) >>> 30);
        h_q   <= h_q * $signed({1'b0, inv_wb_q});
      end
      bmdr_pkg::ST_CORD1: begin
        amp_q <= (((h_q >>> 20) * $signed({1'b0, bmdr_pkg::BinPerRad})) >>> 4);
      end
      bmdr_pkg::ST_DIV: begin
        t_q <= dquot;
        // low half of amp*t, the upper half joins in the next cycle
        if (ddone) tmp_q <= 64'($signed({1'b0, amp_q[31:0]}) * $signed(dquot[31:0]));
      end
      bmdr_pkg::ST_YAW1: tmp_q <= tmp_q + $signed({amp_q[63:32] * t_q[31:0], 32'd0});
      bmdr_pkg::ST_YAW2: ang_q <= yaw_q + tmp_q[63:32];
      bmdr_pkg::ST_CORD2: begin
        h_q <= 64'(v_q * $signed({1'b0, dt_q}));
        if (cdone) begin
          dx_q <= 64'($signed(h_q[36:0]) * $signed(ccos[35:6]));
          dy_q <= 64'($signed(h_q[36:0]) * $signed(csin[35:6]));
        end
      end
      bmdr_pkg::ST_POS1: ang_q <= 32'(yaw_q + 32'h40000000) >> 1;
      bmdr_pkg::ST_CORD3: if (cdone) begin
        qz_q <= bmdr_pkg::q15(csin);
        qw_q <= bmdr_pkg::q15(ccos);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= (st_d == bmdr_pkg::ST_OUT);
    end
  end

  assign out_bus.valid   = out_vld_q;
  assign out_bus.pos_x   = x_q;
  assign out_bus.pos_y   = y_q;
  assign out_bus.heading = yaw_q;
  assign out_bus.quat_z  = qz_q;
  assign out_bus.quat_w  = qw_q;

  `BMDR_ASSERT(a_rdy_idle, clk_i, rst_ni, !(in_bus.ready && out_bus.valid), "ready with result")
  `BMDR_ASSERT(a_vld_state, clk_i, rst_ni, out_bus.valid == (st_q == bmdr_pkg::ST_OUT), "valid")
  `BMDR_ASSERT_NEXT(a_yaw_hold, clk_i, rst_ni, st_q == bmdr_pkg::ST_IDLE && !in_bus.valid, $stable(yaw_q), "yaw")
  `BMDR_ASSERT(a_one_start, clk_i, rst_ni, !(cstart && dstart), "two units started")
endmodule

// File: hdl/bmdr_cordic_cell.sv
// one rotation step; the vector moves to the next cell every cycle
module bmdr_cordic_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  vld_i,
  input  bmdr_pkg::cordic_vec_t vec_i,
  output logic                  vld_o,
  output bmdr_pkg::cordic_vec_t vec_o
);
  localparam logic signed [33:0] Atan = 34'($signed({2'b00, bmdr_pkg::atan_entry(5'(Idx))}));

  logic                  vld_q;
  bmdr_pkg::cordic_vec_t vec_d, vec_q;

  always_comb begin
    vec_d = vec_i;
    if (vec_i.z >= 0) begin
      vec_d.x = vec_i.x - (vec_i.y >>> Idx);
      vec_d.y = vec_i.y + (vec_i.x >>> Idx);
      vec_d.z = vec_i.z - Atan;
    end else begin
      vec_d.x = vec_i.x + (vec_i.y >>> Idx);
      vec_d.y = vec_i.y - (vec_i.x >>> Idx);
      vec_d.z = vec_i.z + Atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    vec_q <= vec_d;
  end

  assign vld_o = vld_q;
  assign vec_o = vec_q;
endmodule

// File: hdl/bmdr_cordic_chain.sv
// row of cordic cells: fold, N cells, unfold
module bmdr_cordic_chain #(
  parameter int unsigned CordicSteps = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [31:0]        ang_i,
  output logic               done_o,
  output logic signed [35:0] cos_o,
  output logic signed [35:0] sin_o
);
  bmdr_pkg::cordic_vec_t vec [CordicSteps+1];
  logic                  vld [CordicSteps+1];
  logic signed [33:0]    z0;
  logic signed [35:0]    cx_q, sy_q;
  logic                  done_q;

  always_comb begin
    z0 = 34'($signed(ang_i));
    vec[0].flip = 1'b0;
    if (z0 > 34'sd1073741824) begin
      z0 = z0 - 34'sd2147483648;
      vec[0].flip = 1'b1;
    end else if (z0 < -34'sd1073741824) begin
      z0 = z0 + 34'sd2147483648;
      vec[0].flip = 1'b1;
    end
    vec[0].x = bmdr_pkg::CordicX0;
    vec[0].y = '0;
    vec[0].z = z0;
    vld[0] = start_i;
  end

  for (genvar g = 0; g < CordicSteps; g++) begin : g_cell
    bmdr_cordic_cell #(.Idx(g)) u_cell (
      .clk_i, .rst_ni,
      .vld_i(vld[g]), .vec_i(vec[g]),
      .vld_o(vld[g+1]), .vec_o(vec[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld[CordicSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q <= vec[CordicSteps].flip ? -vec[CordicSteps].x : vec[CordicSteps].x;
    sy_q <= vec[CordicSteps].flip ? -vec[CordicSteps].y : vec[CordicSteps].y;
  end

  assign done_o = done_q;
  assign cos_o = cx_q;
  assign sin_o = sy_q;
endmodule

// File: hdl/bmdr_divider.sv
// restoring divider, one quotient bit per cycle: trunc(s*65536/c), saturated
module bmdr_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [35:0] num_i,
  input  logic signed [35:0] den_i,
  output logic               done_o,
  output logic signed [63:0] quot_o
);
  localparam int unsigned Nb = 52;

  logic [Nb-1:0] n_q, q_q;
  logic [36:0]   r_q;
  logic [35:0]   dv_q;
  logic          neg_q, busy_q, done_q, zero_q, sgn_q;
  logic [5:0]    cnt_q;
  logic [36:0]   rs;
  logic [Nb-1:0] an;
  logic [35:0]   ad;
  logic signed [63:0] qs;

  always_comb begin
    an = num_i[35] ? Nb'(-{num_i, 16'd0}) : Nb'({num_i, 16'd0});
    ad = den_i[35] ? 36'(-den_i) : 36'(den_i);
    rs = {r_q[35:0], n_q[Nb-1]};
    qs = neg_q ? -$signed({12'd0, q_q}) : $signed({12'd0, q_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(Nb - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= an;
      dv_q  <= ad;
      r_q   <= '0;
      q_q   <= '0;
      neg_q <= num_i[35] ^ den_i[35];
      zero_q <= (den_i == '0);
      sgn_q <= num_i[35];
    end else if (busy_q) begin
      n_q <= {n_q[Nb-2:0], 1'b0};
      if (rs >= {1'b0, dv_q}) begin
        r_q <= rs - {1'b0, dv_q};
        q_q <= {q_q[Nb-2:0], 1'b1};
      end else begin
        r_q <= rs;
        q_q <= {q_q[Nb-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (zero_q) quot_o = sgn_q ? -bmdr_pkg::TanMax : bmdr_pkg::TanMax;
    else if (qs > bmdr_pkg::TanMax) quot_o = bmdr_pkg::TanMax;
    else if (qs < -bmdr_pkg::TanMax) quot_o = -bmdr_pkg::TanMax;
    else quot_o = qs;
  end

  assign done_o = done_q;
endmodule
